// ===== hdl/bcsh_pkg.sv =====
// Shared constants and types for the bit crusher sample-and-hold core.
package bcsh_pkg;

  // Number of channels with their own phasor and held sample.
  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field and register widths.
  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 24;
  localparam int DEPTH_W   = 5;
  localparam int RATIO_W   = 14;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Gain is unsigned Q5.11.
  localparam int GAIN_FRAC = 11;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W  = PROD_W - GAIN_FRAC;

  // Register reset values.
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(24);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(256);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(2048);

  // Legal ranges.
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(24);
  localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(256);
  localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(10240);
  localparam logic [RATIO_W:0]   ONE_Q68   = (RATIO_W+1)'(256);

  localparam logic signed [SCALED_W-1:0] SAT_HI = SCALED_W'(8388607);
  localparam logic signed [SCALED_W-1:0] SAT_LO = -SCALED_W'(8388608);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_DEPTH        = 2'd0,
    REG_DOWNSAMPLE_RATIO = 2'd1,
    REG_DRIVE_GAIN       = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/bit_crusher_sample_hold_core.sv =====
// Bit crusher with per-channel sample-and-hold and floor quantisation.

// One transaction in, one transaction out. Each input sample passes through
// an input register and a result register, with the phasor update, drive
// multiply, saturation and bit masking in the logic between them, so the
// core takes a new transaction every cycle unless both registers are full
// and out_ready is low. A result is offered once its input has moved from
// the input register into the result register. The per-channel phasor and
// held sample are written at the same edge that loads the result register,
// so consecutive samples of one channel always see up-to-date state.
// Configuration registers should only be written while no transaction is in
// flight.
module bit_crusher_sample_hold_core
  import bcsh_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CHANNEL_W-1:0]        channel,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  sample_out
);

  logic [DEPTH_W-1:0] bit_depth;
  logic [RATIO_W-1:0] downsample_ratio;
  logic [GAIN_W-1:0]  drive_gain;

  logic [RATIO_W-1:0]        phase_accum [CHANNELS];
  logic [SAMPLE_W-1:0]       held_sample [CHANNELS];

  logic                      stage_valid;
  logic [CHANNEL_W-1:0]      stage_channel;
  logic signed [SAMPLE_W-1:0] stage_sample;

  logic                      advance;
  logic                      ch_ok;
  logic [CH_IDX_W-1:0]       ch_idx;
  logic [RATIO_W-1:0]        ratio;
  logic [DEPTH_W-1:0]        depth;
  logic [DEPTH_W-1:0]        drop_bits;
  logic [RATIO_W:0]          phase_inc;
  logic                      take;
  logic [RATIO_W-1:0]        phase_next;
  logic signed [PROD_W-1:0]  product;
  logic signed [SCALED_W-1:0] scaled;
  logic [SAMPLE_W-1:0]       driven;
  logic [SAMPLE_W-1:0]       keep_mask;
  logic [SAMPLE_W-1:0]       crushed;
  logic [SAMPLE_W-1:0]       held_next;
  logic [SAMPLE_W-1:0]       result;

  // The input stage moves on when the result register is empty or drained.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth        <= DEPTH_RESET;
      downsample_ratio <= RATIO_RESET;
      drive_gain       <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIT_DEPTH:        bit_depth        <= cfg_data[DEPTH_W-1:0];
        REG_DOWNSAMPLE_RATIO: downsample_ratio <= cfg_data[RATIO_W-1:0];
        REG_DRIVE_GAIN:       drive_gain       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_channel <= channel;
      stage_sample  <= sample_in;
    end
  end

  always_comb begin
    ch_ok  = 32'(stage_channel) < CHANNELS;
    ch_idx = CH_IDX_W'(stage_channel);

    if (downsample_ratio < RATIO_MIN) begin
      ratio = RATIO_MIN;
    end else if (downsample_ratio > RATIO_MAX) begin
      ratio = RATIO_MAX;
    end else begin
      ratio = downsample_ratio;
    end

    if (bit_depth < DEPTH_MIN) begin
      depth = DEPTH_MIN;
    end else if (bit_depth > DEPTH_MAX) begin
      depth = DEPTH_MAX;
    end else begin
      depth = bit_depth;
    end
    drop_bits = DEPTH_MAX - depth;

    // Only one subtraction per sample, so the phasor stays below the
    // largest ratio plus one step.
    phase_inc = {1'b0, phase_accum[ch_idx]} + ONE_Q68;
    take      = phase_inc >= {1'b0, ratio};
    if (take) begin
      phase_next = RATIO_W'(phase_inc - {1'b0, ratio});
    end else begin
      phase_next = RATIO_W'(phase_inc);
    end

    // Arithmetic shift floors the scaled product, as required.
    product = stage_sample * $signed({1'b0, drive_gain});
    scaled  = SCALED_W'(product >>> GAIN_FRAC);
    if (scaled > SAT_HI) begin
      driven = SAMPLE_W'(SAT_HI);
    end else if (scaled < SAT_LO) begin
      driven = SAMPLE_W'(SAT_LO);
    end else begin
      driven = SAMPLE_W'(scaled);
    end

    // Clearing low bits of the offset-binary form leaves the sign bit alone,
    // so the mask can be applied to the two's complement value directly.
    keep_mask = {SAMPLE_W{1'b1}} << drop_bits;
    crushed   = driven & keep_mask;

    held_next = take ? crushed : held_sample[ch_idx];
    result    = ch_ok ? held_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_accum[i] <= '0;
        held_sample[i] <= '0;
      end
    end else if (advance && ch_ok) begin
      phase_accum[ch_idx] <= phase_next;
      held_sample[ch_idx] <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= $signed(result);
    end
  end

  // The input side stalls only when both registers are occupied and blocked.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("input stalled while the pipeline could move");

  // A staged sample with room downstream produces a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && (!out_valid || out_ready)) |=> out_valid)
    else $error("staged transaction lost");

  // The quantiser always keeps at least one bit.
  assert property (@(posedge clk) disable iff (rst)
    drop_bits < DEPTH_MAX)
    else $error("quantiser would clear every bit");

  // After its update the phasor stays below the largest ratio plus one step.
  assert property (@(posedge clk) disable iff (rst)
    advance |-> (phase_next < RATIO_MAX + RATIO_W'(256)))
    else $error("phasor out of range");

endmodule
